>>> rtl/prefix_varint_stream_decoder_macros.svh
// ----------------------------------------------------------------------------
// prefix_varint_stream_decoder_macros
// Assertion helpers for the prefix-length varint stream decoder.
// ----------------------------------------------------------------------------
`ifndef PREFIX_VARINT_STREAM_DECODER_MACROS_SVH
`define PREFIX_VARINT_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PVSD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pvsd assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PVSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pvsd assertion failed");

`endif

>>> rtl/pvsd_pkg.sv
// ----------------------------------------------------------------------------
// pvsd_pkg
// Constants and helper functions for the prefix-length varint decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pvsd_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PayW    = 7;   // payload bits per continuation word
  localparam int unsigned RemW    = 3;
  localparam int unsigned CountW  = 4;
  localparam int unsigned OverW   = 3;
  localparam int unsigned MaxRead = 8;   // start word plus seven continuations

  localparam logic [PayW-1:0] PayMask = 7'h7F;

  // Count of ones directly below bit 7, scanning down from bit 6.
  function automatic logic [RemW-1:0] lead_ones(input logic [PayW-1:0] b);
    logic [RemW-1:0] n;
    logic            run;
    n   = '0;
    run = 1'b1;
    for (int i = PayW - 1; i >= 0; i--) begin
      if (run && b[i]) begin
        n = n + 1'b1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  // Seed bits: those below the run of ones and its terminating zero.
  function automatic logic [PayW-1:0] seed_bits(input logic [PayW-1:0] b,
                                                input logic [RemW-1:0] n);
    logic [RemW:0] shamt;
    shamt = {1'b0, n} + 1'b1;
    return b & (PayMask >> shamt);
  endfunction

  // Minimal encoded length, 1 to 6.
  function automatic logic [RemW-1:0] min_len(input logic [ValueW-1:0] v);
    logic [RemW-1:0] len;
    if (v[ValueW-1:6] == '0) begin
      len = 3'd1;
    end else if (v[ValueW-1:12] == '0) begin
      len = 3'd2;
    end else if (v[ValueW-1:18] == '0) begin
      len = 3'd3;
    end else if (v[ValueW-1:24] == '0) begin
      len = 3'd4;
    end else if (v[ValueW-1:30] == '0) begin
      len = 3'd5;
    end else begin
      len = 3'd6;
    end
    return len;
  endfunction

  // Words read beyond the minimal length; zero before any word and if short.
  function automatic logic [OverW-1:0] overlong(input logic [CountW-1:0] rc,
                                                input logic [ValueW-1:0] v);
    logic [CountW-1:0] need;
    logic [CountW-1:0] diff;
    need = {1'b0, min_len(v)};
    diff = rc - need;
    if (rc == '0 || rc < need) begin
      return '0;
    end
    return diff[OverW-1:0];
  endfunction

endpackage

>>> rtl/prefix_varint_stream_decoder.sv
// ----------------------------------------------------------------------------
// prefix_varint_stream_decoder
// One word per cycle (when not stalled) decoder for a prefix-length variable unsigned integer.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   in      | sink      | in_valid_i / in_stall_o | in_byte_i
//   out     | source    | out_valid_o/out_stall_i | complete_o, rejected_o,
//           |           |                         | decoded_value_o,
//           |           |                         | overlong_count_o
//
// Each accepted word gives one result (input register, then decode logic into
// the result register); one word per cycle with no bubble while out_stall_i
// is low, as the decode state updates in the same step that loads the result.
// rst_ni clears both valid flags and the decode state asynchronously.
// An output stall holds the result register and backs up into the input
// register; in_stall_o rises only when both stages are full and stuck.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "prefix_varint_stream_decoder_macros.svh"

module prefix_varint_stream_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pvsd_pkg::ByteW-1:0]          in_byte_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                complete_o,
  output logic                                rejected_o,
  output logic [pvsd_pkg::ValueW-1:0]         decoded_value_o,
  output logic [pvsd_pkg::OverW-1:0]          overlong_count_o
);

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic                          in_vld_q;
  logic [pvsd_pkg::ByteW-1:0]    in_byte_q;
  logic                          out_vld_q;

  logic out_free;   // result register can take a new result this cycle
  logic advance;    // input register moves into the result register
  logic in_take;    // input word accepted

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Decode state
  // --------------------------------------------------------------------------
  logic [pvsd_pkg::RemW-1:0]     rem_q,   rem_d;
  logic [pvsd_pkg::CountW-1:0]   rc_q,    rc_d;
  logic [pvsd_pkg::ValueW-1:0]   acc_q,   acc_d;
  logic                          cmpl_d,  rej_d;
  logic [pvsd_pkg::OverW-1:0]    over_d;

  logic [pvsd_pkg::PayW-1:0]     pay;
  logic [pvsd_pkg::RemW-1:0]     run_len;

  assign pay     = in_byte_q[pvsd_pkg::PayW-1:0];
  assign run_len = pvsd_pkg::lead_ones(pay);

  always_comb begin
    rem_d  = rem_q;
    rc_d   = rc_q;
    acc_d  = acc_q;
    cmpl_d = 1'b0;
    rej_d  = 1'b0;
    if (!in_byte_q[pvsd_pkg::ByteW-1]) begin
      // start word: abandons anything unfinished
      rem_d  = run_len;
      rc_d   = pvsd_pkg::CountW'(1);
      acc_d  = {{(pvsd_pkg::ValueW - pvsd_pkg::PayW){1'b0}},
                pvsd_pkg::seed_bits(pay, run_len)};
      cmpl_d = (run_len == '0);
    end else if (rem_q != '0) begin
      rem_d  = rem_q - 1'b1;
      rc_d   = rc_q + 1'b1;
      acc_d  = {acc_q[pvsd_pkg::ValueW-pvsd_pkg::PayW-1:0], pay};
      cmpl_d = (rem_q == pvsd_pkg::RemW'(1));
    end else begin
      // stray continuation word: state kept
      rej_d  = 1'b1;
    end
    over_d = pvsd_pkg::overlong(rc_d, acc_d);
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      rem_q     <= '0;
      rc_q      <= '0;
      acc_q     <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        rem_q     <= rem_d;
        rc_q      <= rc_d;
        acc_q     <= acc_d;
      end else if (out_free) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_byte_i;
    end
    if (advance) begin
      complete_o       <= cmpl_d;
      rejected_o       <= rej_d;
      decoded_value_o  <= acc_d;
      overlong_count_o <= over_d;
    end
  end

  assign out_valid_o = out_vld_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PVSD_ASSERT_IMPL(a_cmpl_not_rej, out_vld_q && complete_o, !rejected_o)
  `PVSD_ASSERT_IMPL(a_rej_idle_state, out_vld_q && rejected_o, rem_q == '0)
  `PVSD_ASSERT_IMPL(a_rem_needs_count, rem_q != '0, rc_q != '0)
  `PVSD_ASSERT_IMPL(a_count_bound, rc_q != '0,
                    ({1'b0, rc_q} + {2'b0, rem_q}) <= 5'(pvsd_pkg::MaxRead))
  `PVSD_ASSERT_NEXT(a_stall_holds_state, !advance,
                    $stable(rem_q) && $stable(rc_q) && $stable(acc_q))

endmodule
